>>> src/sqd_pkg.sv
// Shared types, constants and helpers for the shortest-queue ticket dispatcher.
// Used by the channel interfaces, the register block, controller and datapath.
// Depends on nothing.
package sqd_pkg;

  // Built size of the queue set.
  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_QUEUES  = 3;

  // Derived widths.
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int QIDX_W = $clog2(NUM_QUEUES);
  localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // Fixed field widths of the channels.
  localparam int TICKET_W = 32;
  localparam int LIMIT_W  = 5;
  localparam int FILL_W   = 5;
  localparam int CMP_W    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic CFG_REG_QUEUE_LIMIT = 1'b0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  // Request commands.
  localparam logic CMD_ISSUE = 1'b0;
  localparam logic CMD_SERVE = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_BADQ  = 2'd3
  } sqd_status_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIN
  } sqd_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic latch;
    logic exec;
    logic finish;
  } sqd_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic out_free;
  } sqd_stat_t;

endpackage

>>> src/sqd_in_if.sv
// Request channel: a command and a queue index with valid/ready handshake.
// Depends on sqd_pkg.
interface sqd_in_if;
  import sqd_pkg::*;

  logic       valid;
  logic       ready;
  logic       cmd;
  logic [1:0] queue_index;

  modport source (output valid, output cmd, output queue_index, input ready);
  modport sink (input valid, input cmd, input queue_index, output ready);
endinterface

>>> src/sqd_out_if.sv
// Result channel: status, ticket, queue used and the three fill counts.
// Depends on sqd_pkg.
interface sqd_out_if;
  import sqd_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [TICKET_W-1:0] ticket_number;
  logic [1:0]          queue_used;
  logic [FILL_W-1:0]   fill_first;
  logic [FILL_W-1:0]   fill_second;
  logic [FILL_W-1:0]   fill_third;

  modport source (output valid, output status, output ticket_number, output queue_used,
                  output fill_first, output fill_second, output fill_third,
                  input ready);
  modport sink (input valid, input status, input ticket_number, input queue_used,
                input fill_first, input fill_second, input fill_third,
                output ready);
endinterface

>>> src/sqd_regs.sv
// APB-style configuration register block holding the queue limit.
// Depends on sqd_pkg.
module sqd_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sqd_pkg::CFG_AW-1:0] paddr,
  input  logic [sqd_pkg::CFG_DW-1:0] pwdata,
  output logic [sqd_pkg::CFG_DW-1:0] prdata,
  output logic                      pready,
  output logic [sqd_pkg::LIMIT_W-1:0] queue_limit
);
  import sqd_pkg::*;

  logic [LIMIT_W-1:0] limit_r;
  logic               wr_en;
  logic               hit_limit;

  // Register index is the word address.
  assign hit_limit = (paddr[2] == CFG_REG_QUEUE_LIMIT);
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  // The limit register keeps the low bits of the written word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (wr_en && hit_limit) begin
      limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  // Read back; addresses beyond the register list read as zero.
  assign prdata      = hit_limit ? CFG_DW'(limit_r) : '0;
  assign queue_limit = limit_r;
endmodule

>>> src/sqd_ctrl.sv
// Controller state machine: accepts a request, runs it through the datapath
// and hands the result to the output register. Depends on sqd_pkg.
module sqd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sqd_pkg::sqd_stat_t stat,
  output sqd_pkg::sqd_cmd_t  cmd
);
  import sqd_pkg::*;

  sqd_state_t state_r;
  sqd_state_t state_nxt;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output logic.
  always_comb begin
    in_ready   = 1'b0;
    cmd.latch  = 1'b0;
    cmd.exec   = 1'b0;
    cmd.finish = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_FIN: begin
        cmd.finish = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

>>> src/sqd_dp.sv
// Datapath: queue pointers, fill counts, ticket counter, ticket memory and
// the output register. Depends on sqd_pkg.
module sqd_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sqd_pkg::sqd_cmd_t           cmd,
  output sqd_pkg::sqd_stat_t          stat,
  input  logic [sqd_pkg::LIMIT_W-1:0] queue_limit,
  input  logic                        in_cmd,
  input  logic [1:0]                  in_queue_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [sqd_pkg::TICKET_W-1:0] out_ticket_number,
  output logic [1:0]                  out_queue_used,
  output logic [sqd_pkg::FILL_W-1:0]  out_fill_first,
  output logic [sqd_pkg::FILL_W-1:0]  out_fill_second,
  output logic [sqd_pkg::FILL_W-1:0]  out_fill_third
);
  import sqd_pkg::*;

  // Ticket store, one region of QUEUE_DEPTH words per queue.
  logic [TICKET_W-1:0] mem [MEM_DEPTH];
  logic [TICKET_W-1:0] rd_data_r;

  logic [PTR_W-1:0]    head_r [NUM_QUEUES];
  logic [PTR_W-1:0]    tail_r [NUM_QUEUES];
  logic [CNT_W-1:0]    fill_r [NUM_QUEUES];
  logic [TICKET_W-1:0] next_ticket_r;

  // Latched request.
  logic                cmd_r;
  logic [1:0]          qi_r;

  // Result of the execute step.
  sqd_status_t         res_status_r;
  logic [TICKET_W-1:0] res_ticket_r;
  logic [1:0]          res_used_r;
  logic                from_mem_r;

  // Output register.
  logic                out_valid_r;
  sqd_status_t         out_status_r;
  logic [TICKET_W-1:0] out_ticket_r;
  logic [1:0]          out_used_r;
  logic [FILL_W-1:0]   out_fill_r [3];

  logic                found;
  logic [QIDX_W-1:0]   best;
  logic [CNT_W-1:0]    best_fill;
  logic [QIDX_W-1:0]   srv_q;
  logic                srv_ok;
  logic                srv_empty;
  logic                do_issue;
  logic                do_serve;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   rd_addr;

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [QIDX_W-1:0] q,
                                                 input logic [PTR_W-1:0] p);
    mem_addr = ADDR_W'(int'(q) * QUEUE_DEPTH + int'(p));
  endfunction

  function automatic logic [PTR_W-1:0] bump_ptr(input logic [PTR_W-1:0] p);
    bump_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Least-filled queue below the limit; the lowest index wins a tie.
  always_comb begin
    found     = 1'b0;
    best      = '0;
    best_fill = '0;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      if ((CMP_W'(fill_r[q]) < CMP_W'(queue_limit)) &&
          (fill_r[q] < CNT_W'(QUEUE_DEPTH)) &&
          (!found || fill_r[q] < best_fill)) begin
        found     = 1'b1;
        best      = QIDX_W'(q);
        best_fill = fill_r[q];
      end
    end
  end

  // Serve checks on the named queue.
  assign srv_ok    = int'(qi_r) < NUM_QUEUES;
  assign srv_q     = QIDX_W'(qi_r);
  assign srv_empty = srv_ok ? (fill_r[srv_q] == '0) : 1'b1;
  assign do_issue  = cmd.exec && (cmd_r == CMD_ISSUE) && found;
  assign do_serve  = cmd.exec && (cmd_r == CMD_SERVE) && srv_ok && !srv_empty;
  assign wr_addr   = mem_addr(best, tail_r[best]);
  assign rd_addr   = mem_addr(srv_q, head_r[srv_q]);

  // Ticket memory with registered read.
  always_ff @(posedge clk) begin
    if (do_issue) mem[wr_addr] <= next_ticket_r;
    if (do_serve) rd_data_r <= mem[rd_addr];
  end

  // Request latch.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r <= in_cmd;
      qi_r  <= in_queue_index;
    end
  end

  // Queue state and ticket counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        head_r[q] <= '0;
        tail_r[q] <= '0;
        fill_r[q] <= '0;
      end
      next_ticket_r <= TICKET_W'(1);
    end else begin
      if (do_issue) begin
        tail_r[best]  <= bump_ptr(tail_r[best]);
        fill_r[best]  <= fill_r[best] + CNT_W'(1);
        next_ticket_r <= (next_ticket_r == '1) ? TICKET_W'(1) : next_ticket_r + TICKET_W'(1);
      end
      if (do_serve) begin
        head_r[srv_q] <= bump_ptr(head_r[srv_q]);
        fill_r[srv_q] <= fill_r[srv_q] - CNT_W'(1);
      end
    end
  end

  // Status, ticket and queue of the executed request.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_ticket_r <= '0;
      res_used_r   <= '0;
      from_mem_r   <= 1'b0;
      priority if (cmd_r == CMD_ISSUE) begin
        if (found) begin
          res_status_r <= STAT_DONE;
          res_ticket_r <= next_ticket_r;
          res_used_r   <= 2'(best);
        end else begin
          res_status_r <= STAT_FULL;
        end
      end else if (!srv_ok) begin
        res_status_r <= STAT_BADQ;
      end else if (srv_empty) begin
        res_status_r <= STAT_EMPTY;
      end else begin
        res_status_r <= STAT_DONE;
        res_used_r   <= qi_r;
        from_mem_r   <= 1'b1;
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload; fills are taken after the update.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= res_status_r;
      out_ticket_r <= from_mem_r ? rd_data_r : res_ticket_r;
      out_used_r   <= res_used_r;
      for (int k = 0; k < 3; k++) begin
        out_fill_r[k] <= '0;
        for (int q = 0; q < NUM_QUEUES; q++) begin
          if (q == k) out_fill_r[k] <= FILL_W'(fill_r[q]);
        end
      end
    end
  end

  assign stat.out_free     = !out_valid_r || out_ready;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_ticket_number = out_ticket_r;
  assign out_queue_used    = out_used_r;
  assign out_fill_first    = out_fill_r[0];
  assign out_fill_second   = out_fill_r[1];
  assign out_fill_third    = out_fill_r[2];
endmodule

>>> src/shortest_queue_ticket_dispatcher.sv
// Shortest-queue ticket dispatcher, top level.
// Each request is accepted, then executed (ticket memory write or read), then
// loaded into the output register; a stalled output holds the last step. Only
// one request is handled at a time; the next is accepted after the load.
// Reset: synchronous, active low; clears queues, ticket counter to 1, limit to 16.
module shortest_queue_ticket_dispatcher (
  input  logic                        clk,
  input  logic                        rst_n,
  sqd_in_if.sink                      in_ch,
  sqd_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sqd_pkg::CFG_AW-1:0]  paddr,
  input  logic [sqd_pkg::CFG_DW-1:0]  pwdata,
  output logic [sqd_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import sqd_pkg::*;

  logic [LIMIT_W-1:0] queue_limit;
  sqd_cmd_t           cmd;
  sqd_stat_t          stat;

  // Configuration registers.
  sqd_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .queue_limit (queue_limit)
  );

  // Sequencing of each request.
  sqd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Queue storage and result generation.
  sqd_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .queue_limit       (queue_limit),
    .in_cmd            (in_ch.cmd),
    .in_queue_index    (in_ch.queue_index),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_status        (out_ch.status),
    .out_ticket_number (out_ch.ticket_number),
    .out_queue_used    (out_ch.queue_used),
    .out_fill_first    (out_ch.fill_first),
    .out_fill_second   (out_ch.fill_second),
    .out_fill_third    (out_ch.fill_third)
  );

`ifndef SYNTHESIS
  // Only one request is in flight: after an accept the block is busy.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while another is in flight");

  // A result that is not done carries no ticket and no queue.
  a_not_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != STAT_DONE)) |->
      ((out_ch.ticket_number == '0) && (out_ch.queue_used == '0)))
    else $error("failed request reports a ticket");

  // An issued or served ticket is never zero.
  a_done_ticket: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == STAT_DONE)) |-> (out_ch.ticket_number != '0))
    else $error("ticket zero reported as done");
`endif
endmodule
